[design/rsti_pkg.sv]
// shared constants and character helpers for the radix string to integer parser
package rsti_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int OFFSET_BITS = 16;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [6:0] NO_DIGIT    = 7'd99;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [VALUE_BITS-1:0]  accum_t;

  function automatic logic [6:0] char_digit(input logic [7:0] c);
    logic [6:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 7'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = 7'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = 7'(c - 8'h41 + 8'd10);
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

[design/radix_string_to_integer_core.sv]
// streaming strtol-style parser: one character per item, one result per number
//
// One character is taken per cycle while in_ready is high. Each item sits in an
// input register, where one multiply-add by the active base (up to 36) updates the
// accumulator, so the sustained rate is one item per clock while results are taken.
// A result is held in an output register; the input register still fills while it
// waits, and only an item that would produce a second result stalls. The result is
// registered as the stop character leaves the input register; radix_r is sampled
// as the start_req item advances. Radix 0 detects the base from a 0 or 0x prefix.
module radix_string_to_integer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_radix,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_character,
  input  logic                in_start_req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_value,
  output logic [15:0]         out_end_offset
);
  import rsti_pkg::*;

  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_XSEEN  = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  localparam offset_t OFFSET_LIMIT = '1;

  logic [5:0]  radix_r;
  logic        in_v_r;
  logic [7:0]  char_r;
  logic        start_r;
  logic [2:0]  ph_r, ph_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  base_r, base_nxt;
  accum_t      acc_r, acc_nxt;
  offset_t     cons_r, cons_nxt;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [15:0] out_offset_r;

  logic        adv;
  logic        emit_c;
  logic        any_c;
  logic        try_c;
  logic        sgn_path;
  logic [1:0]  inc_c;
  logic [6:0]  dig_c;
  logic [2:0]  ph_s;
  offset_t     cons_s;
  logic [OFFSET_BITS:0] cons_sum;
  accum_t      signed_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= cfg_radix;
    end
  end

  assign dig_c = char_digit(char_r);

  always_comb begin
    ph_s     = ph_r;
    neg_nxt  = neg_r;
    base_nxt = base_r;
    acc_nxt  = acc_r;
    cons_s   = cons_r;
    emit_c   = 1'b0;
    any_c    = 1'b0;
    try_c    = 1'b0;
    sgn_path = 1'b0;
    inc_c    = 2'd0;
    if (start_r) begin
      ph_s     = PH_LEAD;
      neg_nxt  = 1'b0;
      base_nxt = (radix_r > RADIX_MAX) ? RADIX_MAX : radix_r;
      acc_nxt  = '0;
      cons_s   = '0;
    end
    ph_nxt = ph_s;
    unique case (ph_s)
      PH_LEAD: begin
        if (is_space(char_r)) begin
          inc_c = 2'd1;
        end else if (char_r == 8'h2d || char_r == 8'h2b) begin
          neg_nxt = (char_r == 8'h2d);
          inc_c   = 2'd1;
          ph_nxt  = PH_SIGNED;
        end else begin
          sgn_path = 1'b1;
        end
      end
      PH_SIGNED: sgn_path = 1'b1;
      PH_ZERO: begin
        if (char_r == 8'h78 || char_r == 8'h58) begin
          base_nxt = 6'd16;
          ph_nxt   = PH_XSEEN;
        end else begin
          if (base_nxt == 6'd0) base_nxt = 6'd8;
          try_c = 1'b1;
          any_c = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (dig_c < 7'd16) begin
          acc_nxt = VALUE_BITS'(dig_c);
          inc_c   = 2'd2;
          ph_nxt  = PH_DIGITS;
        end else begin
          emit_c = 1'b1;
          any_c  = 1'b1;
        end
      end
      PH_DIGITS: begin
        try_c = 1'b1;
        any_c = 1'b1;
      end
      default: ph_nxt = PH_DONE;
    endcase
    if (sgn_path) begin
      if (char_r == 8'h30 && (base_nxt == 6'd0 || base_nxt == 6'd16)) begin
        inc_c  = 2'd1;
        ph_nxt = PH_ZERO;
      end else begin
        if (base_nxt == 6'd0) base_nxt = 6'd10;
        try_c = 1'b1;
      end
    end
    if (try_c) begin
      if (dig_c < {1'b0, base_nxt}) begin
        acc_nxt = VALUE_BITS'(acc_nxt * base_nxt) + VALUE_BITS'(dig_c);
        inc_c   = 2'd1;
        ph_nxt  = PH_DIGITS;
      end else begin
        emit_c = 1'b1;
      end
    end
    if (emit_c) ph_nxt = PH_DONE;
    cons_sum = {1'b0, cons_s} + (OFFSET_BITS+1)'(inc_c);
    cons_nxt = (cons_sum > {1'b0, OFFSET_LIMIT}) ? OFFSET_LIMIT : cons_sum[OFFSET_BITS-1:0];
    signed_acc = neg_nxt ? (VALUE_BITS'(0) - acc_nxt) : acc_nxt;
  end

  assign adv      = in_v_r && (!emit_c || !out_valid_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r  <= in_character;
      start_r <= in_start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_DONE;
      neg_r  <= 1'b0;
      base_r <= '0;
      acc_r  <= '0;
      cons_r <= '0;
    end else if (adv) begin
      ph_r   <= ph_nxt;
      neg_r  <= neg_nxt;
      base_r <= base_nxt;
      acc_r  <= acc_nxt;
      cons_r <= cons_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit_c) begin
      out_value_r  <= any_c ? 64'(signed'(signed_acc)) : 64'd0;
      out_offset_r <= any_c ? 16'(cons_s) : 16'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = signed'(out_value_r);
  assign out_end_offset = out_offset_r;

  a_zero_offset_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_offset_r == 16'd0) |-> out_value_r == 64'd0)
    else $error("result with no consumed characters has a nonzero value");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> (in_v_r && $stable(char_r) && $stable(start_r)))
    else $error("stalled item lost from input register");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_value_r)
                                     && $stable(out_offset_r)))
    else $error("waiting result overwritten");

  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit_c) |=> ph_r == PH_DONE)
    else $error("parser not done after result");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_DONE) |-> base_r <= RADIX_MAX)
    else $error("active base above 36");

endmodule
